// ----- hdl/scoped_symbol_table_top_macros.svh -----
// Assertion macros shared by the verification code of the symbol table.
// Depends on nothing; the user supplies clk and rst_n in scope.
`ifndef SCOPED_SYMBOL_TABLE_TOP_MACROS_SVH
`define SCOPED_SYMBOL_TABLE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/sst_pkg.sv -----
// Shared types and codes of the scoped symbol table.
// No dependencies; imported by the top level and the checker.
package sst_pkg;

    // Operation codes
    localparam logic [2:0] KIND_INSERT     = 3'd0;
    localparam logic [2:0] KIND_LOOKUP_ALL = 3'd1;
    localparam logic [2:0] KIND_LOOKUP_BLK = 3'd2;
    localparam logic [2:0] KIND_READ       = 3'd3;
    localparam logic [2:0] KIND_PUSH       = 3'd4;
    localparam logic [2:0] KIND_POP        = 3'd5;
    localparam logic [2:0] KIND_FINALIZE   = 3'd6;

    // Status codes
    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_TABLE_FULL = 3'd1;
    localparam logic [2:0] STATUS_MARK_EMPTY = 3'd2;
    localparam logic [2:0] STATUS_MARK_FULL  = 3'd3;
    localparam logic [2:0] STATUS_RANGE      = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] symbol;
        logic [31:0] payload;
        logic [9:0]  index;
    } req_item_t;

    typedef struct packed {
        logic        found;
        logic [9:0]  entry_index;
        logic [31:0] entry_info;
        logic [31:0] entry_symbol;
        logic        in_global;
        logic [10:0] entry_count;
        logic [10:0] peak_count;
        logic [2:0]  status;
    } rsp_item_t;

endpackage

// ----- hdl/sst_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module sst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/scoped_symbol_table_top.sv -----
// Scoped symbol table: one request in, one response out per operation. Entries and
// block marks live in two RAMs with registered reads and are not cleared at reset.
// Insert, push, finalize, unused codes and rejected reads or pops go from idle
// straight to the response state; a read-by-index or pop that touches a RAM first
// waits for the RAM read. A lookup walks the entry RAM one read per cycle from the
// newest entry down to the block floor; a block lookup with a block open first reads
// the top mark to find that floor. A new request is taken while the previous
// response waits.
// Depends on sst_pkg and sst_ram.
module scoped_symbol_table_top
    import sst_pkg::*;
#(
    parameter int ENTRY_DEPTH  = 1024,
    parameter int MARK_DEPTH   = 64,
    parameter int SYMBOL_WIDTH = 32,
    parameter int INFO_WIDTH   = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    localparam int SK    = (SYMBOL_WIDTH < 32) ? SYMBOL_WIDTH : 32;
    localparam int IK    = (INFO_WIDTH < 32) ? INFO_WIDTH : 32;
    localparam int CNT_W = $clog2(ENTRY_DEPTH + 1);
    localparam int AW    = $clog2(ENTRY_DEPTH);
    localparam int MDW   = $clog2(MARK_DEPTH + 1);
    localparam int MAW   = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
    localparam int IW    = (CNT_W > 10) ? CNT_W : 10;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_RD_WAIT  = 6'b000010,
        ST_POP_WAIT = 6'b000100,
        ST_LO_WAIT  = 6'b001000,
        ST_SCAN     = 6'b010000,
        ST_RESP     = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] peak_reg, peak_next;
    logic [MDW-1:0]   depth_reg, depth_next;
    logic [CNT_W-1:0] first_mark_reg, first_mark_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             rd_pend_reg, rd_pend_next;
    logic [AW-1:0]    rd_addr_reg, rd_addr_next;
    logic [SK-1:0]    key_reg, key_next;
    rsp_item_t        res_reg, res_next;
    rsp_item_t        rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    logic             ent_we;
    logic [AW-1:0]    ent_raddr;
    logic [SK+IK-1:0] ent_rdata;
    logic             mark_we;
    logic [CNT_W-1:0] mark_rdata;
    logic [SK-1:0]    ram_sym;
    logic [IK-1:0]    ram_info;

    // Entry lies below the first mark, or no block is open
    function automatic logic global_of(input logic [CNT_W-1:0] idx,
                                       input logic [MDW-1:0]   depth,
                                       input logic [CNT_W-1:0] first_mark);
        return (depth == '0) || (idx < first_mark);
    endfunction

    assign ram_sym  = ent_rdata[SK+IK-1:IK];
    assign ram_info = ent_rdata[IK-1:0];

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Entry store: {symbol, info}
    sst_ram #(
        .WIDTH(SK + IK),
        .DEPTH(ENTRY_DEPTH)
    ) u_entry_ram (
        .clk  (clk),
        .we   (ent_we),
        .waddr(AW'(count_reg)),
        .wdata({req.symbol[SK-1:0], req.payload[IK-1:0]}),
        .raddr(ent_raddr),
        .rdata(ent_rdata)
    );

    // Block mark stack; read port always points at the top mark
    sst_ram #(
        .WIDTH(CNT_W),
        .DEPTH(MARK_DEPTH)
    ) u_mark_ram (
        .clk  (clk),
        .we   (mark_we),
        .waddr(MAW'(depth_reg)),
        .wdata(count_reg),
        .raddr(MAW'(depth_reg - 1'b1)),
        .rdata(mark_rdata)
    );

    // Entry read address: scan pointer while scanning, request index otherwise
    assign ent_raddr = (state_reg == ST_SCAN) ? AW'(ptr_reg - 1'b1) : AW'(req.index);

    // Operation sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        peak_next       = peak_reg;
        depth_next      = depth_reg;
        first_mark_next = first_mark_reg;
        lo_next         = lo_reg;
        ptr_next        = ptr_reg;
        rd_pend_next    = rd_pend_reg;
        rd_addr_next    = rd_addr_reg;
        key_next        = key_reg;
        res_next        = res_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        ent_we          = 1'b0;
        mark_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    res_next     = '0;
                    key_next     = req.symbol[SK-1:0];
                    ptr_next     = count_reg;
                    lo_next      = '0;
                    rd_pend_next = 1'b0;
                    state_next   = ST_RESP;
                    unique case (req.kind)
                        KIND_INSERT:
                        begin
                            if (count_reg < CNT_W'(ENTRY_DEPTH))
                            begin
                                ent_we               = 1'b1;
                                res_next.entry_index = 10'(count_reg);
                                res_next.in_global   = global_of(count_reg, depth_reg,
                                                                 first_mark_reg);
                                count_next           = count_reg + 1'b1;
                            end
                            else
                            begin
                                res_next.status = STATUS_TABLE_FULL;
                            end
                        end
                        KIND_LOOKUP_ALL:
                        begin
                            state_next = ST_SCAN;
                        end
                        KIND_LOOKUP_BLK:
                        begin
                            state_next = (depth_reg != '0) ? ST_LO_WAIT : ST_SCAN;
                        end
                        KIND_READ:
                        begin
                            if (IW'(req.index) >= IW'(count_reg))
                            begin
                                res_next.status = STATUS_RANGE;
                            end
                            else
                            begin
                                res_next.entry_index = req.index;
                                res_next.in_global   = global_of(CNT_W'(req.index),
                                                                 depth_reg, first_mark_reg);
                                state_next           = ST_RD_WAIT;
                            end
                        end
                        KIND_PUSH:
                        begin
                            if (depth_reg >= MDW'(MARK_DEPTH))
                            begin
                                res_next.status = STATUS_MARK_FULL;
                            end
                            else
                            begin
                                mark_we = 1'b1;
                                if (depth_reg == '0)
                                begin
                                    first_mark_next = count_reg;
                                end
                                depth_next = depth_reg + 1'b1;
                            end
                        end
                        KIND_POP:
                        begin
                            if (depth_reg == '0)
                            begin
                                res_next.status = STATUS_MARK_EMPTY;
                            end
                            else
                            begin
                                if (count_reg > peak_reg)
                                begin
                                    peak_next = count_reg;
                                end
                                state_next = ST_POP_WAIT;
                            end
                        end
                        KIND_FINALIZE:
                        begin
                            if (count_reg > peak_reg)
                            begin
                                peak_next = count_reg;
                            end
                        end
                        default:
                        begin
                            res_next.status = STATUS_OK;
                        end
                    endcase
                end
            end

            ST_RD_WAIT:
            begin
                res_next.found        = 1'b1;
                res_next.entry_info   = 32'(ram_info);
                res_next.entry_symbol = 32'(ram_sym);
                state_next            = ST_RESP;
            end

            // Cut the table back to the top mark
            ST_POP_WAIT:
            begin
                count_next = mark_rdata;
                depth_next = depth_reg - 1'b1;
                state_next = ST_RESP;
            end

            ST_LO_WAIT:
            begin
                lo_next    = mark_rdata;
                state_next = ST_SCAN;
            end

            // One entry read per cycle, compared in the next cycle
            ST_SCAN:
            begin
                if (rd_pend_reg && (ram_sym == key_reg))
                begin
                    res_next.found       = 1'b1;
                    res_next.entry_index = 10'(rd_addr_reg);
                    res_next.entry_info  = 32'(ram_info);
                    res_next.in_global   = global_of(CNT_W'(rd_addr_reg), depth_reg,
                                                     first_mark_reg);
                    state_next           = ST_RESP;
                end
                else if (ptr_reg > lo_reg)
                begin
                    rd_pend_next = 1'b1;
                    rd_addr_next = AW'(ptr_reg - 1'b1);
                    ptr_next     = ptr_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end

            // Hand the result to the output register once it is free
            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next             = res_reg;
                    rsp_next.entry_count = 11'(count_reg);
                    rsp_next.peak_count  = 11'(peak_reg);
                    rsp_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            peak_reg      <= '0;
            depth_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            peak_reg      <= peak_next;
            depth_reg     <= depth_next;
            rd_pend_reg   <= rd_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        first_mark_reg <= first_mark_next;
        lo_reg         <= lo_next;
        ptr_reg        <= ptr_next;
        rd_addr_reg    <= rd_addr_next;
        key_reg        <= key_next;
        res_reg        <= res_next;
        rsp_reg        <= rsp_next;
    end

endmodule

// ----- hdl/sst_checker.sv -----
// Port-level checks of the scoped symbol table, bound to the top level.
// Depends on sst_pkg and scoped_symbol_table_top_macros.svh.
`include "scoped_symbol_table_top_macros.svh"

module sst_checker
    import sst_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input rsp_item_t rsp
);

    logic [1:0] outstanding_reg, outstanding_next;

    // Requests taken whose responses are not yet transferred
    always_comb
    begin
        outstanding_next = outstanding_reg + 2'(req_valid && req_ready)
                           - 2'(rsp_valid && rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    `SST_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response changed while stalled")
    `SST_ASSERT_NOW(a_no_extra_rsp, rsp_valid, outstanding_reg != 2'd0, "response without a request")
    `SST_ASSERT_NOW(a_found_ok, rsp_valid && rsp.found, rsp.status == STATUS_OK, "hit reported with error status")
    `SST_ASSERT_NOW(a_err_clean, rsp_valid && (rsp.status != STATUS_OK), !rsp.found && (rsp.entry_info == 32'd0) && !rsp.in_global, "error response carries entry data")

endmodule

bind scoped_symbol_table_top sst_checker u_sst_checker (.*);
